FILE: rtl/assert_macros.svh
// Assertion macros shared by the stereo block-match RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ssbm_pkg.sv
// Package for the stereo block matcher: payload types, codes, state enum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssbm_pkg;
  typedef struct packed {
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
  } in_item_t;

  typedef struct packed {
    logic [9:0] map_column;
    logic [9:0] map_row;
    logic [4:0] disparity;
    logic       last_of_run;
  } out_item_t;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
  localparam logic [10:0] WIDTH_RESET  = 11'd752;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;
  localparam logic [10:0] MAX_HEIGHT   = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a pixel
    ST_POS,    // next result position
    ST_CAND,   // start a candidate
    ST_ACC,    // accumulate SAD
    ST_DRAIN,  // last reads in flight
    ST_EMIT    // hand result to output reg
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic write_px;     // store accepted pixel, latch counters
    logic pos_first;    // load first result x
    logic pos_next;     // advance result x
    logic cand_first;   // reset candidate to lo
    logic cand_next;    // advance candidate
    logic sum_clear;    // clear SAD accumulator and tap counter
    logic rd_issue;     // issue a store read for the next tap
    logic cand_done;    // compare finished candidate
    logic emit;         // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;   // accepted pixel produces results
    logic pos_last;     // current x is the last for this pixel
    logic cand_last;    // current candidate is hi
    logic taps_done;    // all BLOCK*BLOCK taps issued
    logic pipe_empty;   // no read in flight
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/ssbm_datapath.sv
// Datapath: counters, line stores, SAD accumulate and best-match search.
// Depends on ssbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssbm_datapath #(
  parameter int BLOCK     = 10,
  parameter int RANGE     = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [10:0]        width_i,
  input  wire logic [10:0]        height_i,
  input  wire ssbm_pkg::in_item_t in_item_i,
  input  wire ssbm_pkg::cmd_t     cmd_i,
  output ssbm_pkg::status_t       status_o,
  output ssbm_pkg::out_item_t     out_item_o
);
  import ssbm_pkg::*;

  localparam int COLW   = $clog2(MAX_WIDTH);
  localparam int SLOTW  = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int DEPTH  = BLOCK * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int TAPS   = BLOCK * BLOCK;
  localparam int TW     = $clog2(TAPS + 1);
  localparam int SW     = $clog2(TAPS * 255 + 1);
  localparam int BW     = $clog2(BLOCK);

  // effective sizes
  logic [10:0] w_eff, h_eff;
  always_comb begin
    w_eff = (width_i > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_i;
    if (w_eff == 11'd0) w_eff = 11'd1;
    h_eff = (height_i > MAX_HEIGHT) ? MAX_HEIGHT : height_i;
    if (h_eff == 11'd0) h_eff = 11'd1;
  end

  // position counters (next pixel) and slot of current row
  logic [9:0] col_q, col_d, row_q, row_d;
  logic [SLOTW-1:0] slot_q, slot_d;
  // position of the pixel being handled
  logic [10:0] pcol_q, prow_q;
  logic [SLOTW-1:0] pslot_q;
  logic [10:0] ccol, crow;
  logic [SLOTW-1:0] cslot;

  always_comb begin
    ccol  = {1'b0, col_q};
    crow  = {1'b0, row_q};
    cslot = slot_q;
    if (ccol >= w_eff) begin
      ccol  = 11'd0;
      crow  = crow + 11'd1;
      cslot = (cslot == SLOTW'(BLOCK - 1)) ? '0 : cslot + 1'b1;
    end
    if (crow >= h_eff) begin
      crow  = 11'd0;
      cslot = '0;
    end
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (cmd_i.write_px) begin
      if (ccol + 11'd1 >= w_eff) begin
        col_d = 10'd0;
        if (crow + 11'd1 >= h_eff) begin
          row_d  = 10'd0;
          slot_d = '0;
        end else begin
          row_d  = 10'(crow + 11'd1);
          slot_d = (cslot == SLOTW'(BLOCK - 1)) ? '0 : cslot + 1'b1;
        end
      end else begin
        col_d  = 10'(ccol + 11'd1);
        row_d  = 10'(crow);
        slot_d = cslot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_px) begin
      pcol_q  <= ccol;
      prow_q  <= crow;
      pslot_q <= cslot;
    end
  end

  // result range for the held pixel
  logic [11:0] lo_c, hi_c, y_c;
  logic        has_c;
  always_comb begin
    y_c = 12'(prow_q) - 12'(BLOCK - 1);
    if (pcol_q == w_eff - 11'd1) begin
      lo_c = 12'(w_eff) - 12'(RANGE + BLOCK);
      hi_c = 12'(w_eff) - 12'(BLOCK + 1);
    end else begin
      lo_c = 12'(pcol_q) - 12'(RANGE + BLOCK - 1);
      hi_c = lo_c;
    end
    if ($signed(lo_c) < $signed(12'(BLOCK))) lo_c = 12'(BLOCK);
    if ($signed(hi_c) >= $signed(12'(w_eff) - 12'(BLOCK)))
      hi_c = 12'(w_eff) - 12'(BLOCK + 1);
    has_c = (prow_q >= 11'(2 * BLOCK - 1)) &&
            ($signed(y_c) < $signed(12'(h_eff) - 12'(BLOCK))) &&
            ($signed(lo_c) <= $signed(hi_c));
  end

  // result x, candidate column
  logic [11:0] x_q, hi_q, cand_q, chi_q;
  logic [11:0] clo_c, chi_c;
  always_comb begin
    clo_c = (x_q < 12'(RANGE)) ? 12'd0 : x_q - 12'(RANGE);
    chi_c = x_q + 12'(RANGE);
    if ($signed(chi_c) > $signed(12'(w_eff) - 12'(BLOCK)))
      chi_c = 12'(w_eff) - 12'(BLOCK);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_first) begin
      x_q  <= lo_c;
      hi_q <= hi_c;
    end else if (cmd_i.pos_next) begin
      x_q <= x_q + 12'd1;
    end
    if (cmd_i.cand_first) begin
      cand_q <= clo_c;
      chi_q  <= chi_c;
    end else if (cmd_i.cand_next) begin
      cand_q <= cand_q + 12'd1;
    end
  end

  // tap walk: dy, dx
  logic [BW-1:0] dy_q, dx_q;
  logic [TW-1:0] taps_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dy_q <= '0;
      dx_q <= '0;
      taps_q <= '0;
    end else if (cmd_i.sum_clear) begin
      dy_q <= '0;
      dx_q <= '0;
      taps_q <= '0;
    end else if (cmd_i.rd_issue) begin
      taps_q <= taps_q + 1'b1;
      if (dx_q == BW'(BLOCK - 1)) begin
        dx_q <= '0;
        dy_q <= dy_q + 1'b1;
      end else begin
        dx_q <= dx_q + 1'b1;
      end
    end
  end

  // row slot of block row dy: y = prow-(BLOCK-1); slot = (pslot+1+dy) mod BLOCK
  logic [SLOTW:0] rs_sum;
  logic [SLOTW-1:0] rslot;
  always_comb begin
    rs_sum = {1'b0, pslot_q} + (SLOTW+1)'(dy_q) + (SLOTW+1)'(1);
    rslot  = (rs_sum >= (SLOTW+1)'(BLOCK)) ? SLOTW'(rs_sum - (SLOTW+1)'(BLOCK))
                                           : SLOTW'(rs_sum);
  end
  logic [11:0] lcol, rcol;
  assign lcol = x_q + 12'(dx_q);
  assign rcol = cand_q + 12'(dx_q);

  logic [AW-1:0] wr_addr, lrd_addr, rrd_addr;
  assign wr_addr  = AW'(32'(cslot) * MAX_WIDTH + 32'(ccol[COLW-1:0]));
  assign lrd_addr = AW'(32'(rslot) * MAX_WIDTH + 32'(lcol[COLW-1:0]));
  assign rrd_addr = AW'(32'(rslot) * MAX_WIDTH + 32'(rcol[COLW-1:0]));

  // line stores, one write and one registered read each
  logic [7:0] lmem [DEPTH];
  logic [7:0] rmem [DEPTH];
  logic [7:0] lrd_q, rrd_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_px) lmem[wr_addr] <= in_item_i.left_pixel;
    lrd_q <= lmem[lrd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_px) rmem[wr_addr] <= in_item_i.right_pixel;
    rrd_q <= rmem[rrd_addr];
  end

  // read valid pipeline
  logic rv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else         rv_q <= cmd_i.rd_issue;
  end

  // SAD accumulator
  logic [SW-1:0] sum_q;
  logic [7:0] ad;
  assign ad = (lrd_q > rrd_q) ? lrd_q - rrd_q : rrd_q - lrd_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clear)  sum_q <= '0;
    else if (rv_q)        sum_q <= sum_q + SW'(ad);
  end

  // best candidate
  logic [SW-1:0] best_q;
  logic [11:0]   bestc_q;
  logic          first_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_first) first_q <= 1'b1;
    else if (cmd_i.cand_done) begin
      first_q <= 1'b0;
      if (first_q || sum_q < best_q) begin
        best_q  <= sum_q;
        bestc_q <= cand_q;
      end
    end
  end

  // output register
  logic [11:0] dis;
  assign dis = (bestc_q > x_q) ? bestc_q - x_q : x_q - bestc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_o.map_column  <= x_q[9:0];
      out_item_o.map_row     <= y_c[9:0];
      out_item_o.disparity   <= dis[4:0];
      out_item_o.last_of_run <= (x_q == hi_q);
    end
  end

  assign status_o.has_result = has_c;
  assign status_o.pos_last   = (x_q == hi_q);
  assign status_o.cand_last  = (cand_q == chi_q);
  assign status_o.taps_done  = (taps_q == TW'(TAPS));
  assign status_o.pipe_empty = !rv_q;

  `ASSERT_IMPLY(a_taps_bound, clk_i, rst_ni, 1'b1, taps_q <= TW'(TAPS))
  `ASSERT_NEXT(a_read_follows, clk_i, rst_ni, cmd_i.rd_issue, rv_q)
  `ASSERT_IMPLY(a_no_issue_done, clk_i, rst_ni, cmd_i.rd_issue, taps_q < TW'(TAPS))
endmodule
`default_nettype wire

FILE: rtl/ssbm_ctrl.sv
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on ssbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssbm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire ssbm_pkg::status_t status_i,
  output ssbm_pkg::cmd_t         cmd_o
);
  import ssbm_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ov_d    = ov_q && !out_ready_i;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.write_px = 1'b1;
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (status_i.has_result) begin
          cmd_o.pos_first = 1'b1;
          state_d = ST_CAND;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CAND: begin
        cmd_o.cand_first = 1'b1;
        cmd_o.sum_clear  = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (status_i.taps_done) state_d = ST_DRAIN;
        else cmd_o.rd_issue = 1'b1;
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          cmd_o.cand_done = 1'b1;
          if (status_i.cand_last) begin
            state_d = ST_EMIT;
          end else begin
            cmd_o.cand_next = 1'b1;
            cmd_o.sum_clear = 1'b1;
            state_d = ST_ACC;
          end
        end
      end
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          ov_d = 1'b1;
          if (status_i.pos_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.pos_next = 1'b1;
            state_d = ST_CAND;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

  `ASSERT_IMPLY(a_emit_free, clk_i, rst_ni, cmd_o.emit, !ov_q || out_ready_i)
  `ASSERT_IMPLY(a_accept_idle, clk_i, rst_ni, cmd_o.write_px, state_q == ST_IDLE)
  `ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd_o.emit, ov_q)
endmodule
`default_nettype wire

FILE: rtl/sad_stereo_block_match.sv
// Top level of the SAD stereo block matcher: config regs, ctrl, datapath.
// Depends on ssbm_pkg, ssbm_ctrl, ssbm_datapath.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid_i/in_ready_o in_item_i (left/right pixel)
// out      out  out_valid_o/out_ready_i out_item_o (column,row,disparity,last)
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Pixels are taken only in ST_IDLE; each result runs ST_CAND, then ST_ACC and
// ST_DRAIN per candidate, then ST_EMIT; one read port per store paces ST_ACC.
// Reset clears counters and control; line stores are not cleared.
// Output register holds one result; the next result waits while it is stalled.
`timescale 1ns / 1ps
`default_nettype none
module sad_stereo_block_match #(
  parameter int BLOCK     = 10,
  parameter int RANGE     = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ssbm_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ssbm_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [10:0]         cfg_data_i
);
  import ssbm_pkg::*;

  logic [10:0] width_q, height_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_WIDTH) width_q  <= cfg_data_i;
      else                          height_q <= cfg_data_i;
    end
  end

  ssbm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  ssbm_datapath #(.BLOCK(BLOCK), .RANGE(RANGE), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i, .rst_ni, .width_i(width_q), .height_i(height_q),
    .in_item_i, .cmd_i(cmd), .status_o(status), .out_item_o
  );
endmodule
`default_nettype wire

FILE: tb/tb_sad_stereo_block_match.sv
// Self-checking testbench for sad_stereo_block_match: pixel streams in, disparity results checked.
// Depends on ssbm_pkg and the sad_stereo_block_match RTL.
// A built-in disparity predictor supplies the expected results; idles and stalls are random.
`timescale 1ns / 1ps
module tb_sad_stereo_block_match;
  import ssbm_pkg::*;

  localparam int BLK       = 10;
  localparam int SRCH      = 1;
  localparam int MAXW      = 1024;
  localparam int LIMIT     = 4000000;
  localparam int SETTLE    = 60;

  typedef enum int {PAT_SHIFT, PAT_MIXED, PAT_FLAT} pattern_e;

  typedef struct {
    logic [7:0] l;
    logic [7:0] r;
    bit         no_result;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_WIDTH;
  logic [10:0] cfg_data = '0;

  // disparity predictor state
  logic [7:0]  left_st  [0:BLK*MAXW-1];
  logic [7:0]  right_st [0:BLK*MAXW-1];
  int          pcol, prow;
  logic [10:0] width_reg, height_reg;
  out_item_t   disp_q[$];

  int          errors = 0;
  int          cycles = 0;
  int          n_pixels = 0;
  int          n_results = 0;
  int          n_cfg = 0;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int          tex [0:MAXW+1];

  sad_stereo_block_match dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, exp, n_results);
    errors++;
  endtask

  function automatic int eff_w();
    int w;
    w = width_reg;
    if (w > MAXW) w = MAXW;
    if (w == 0) w = 1;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = height_reg;
    if (h > 1024) h = 1024;
    if (h == 0) h = 1;
    return h;
  endfunction

  function automatic int unsigned block_sad(input int y, input int xl, input int xr);
    int unsigned sum;
    int a, b;
    sum = 0;
    for (int dy = 0; dy < BLK; dy++)
      for (int dx = 0; dx < BLK; dx++) begin
        a = left_st[((y + dy) % BLK) * MAXW + xl + dx];
        b = right_st[((y + dy) % BLK) * MAXW + xr + dx];
        sum += (a > b) ? a - b : b - a;
      end
    return sum;
  endfunction

  // lowest SAD over the clipped search window, ties to the lowest column
  function automatic int best_offset(input int y, input int x, input int w);
    int lo, hi, best;
    int unsigned s, best_s;
    lo = x - SRCH;
    hi = x + SRCH;
    if (lo < 0) lo = 0;
    if (hi > w - BLK) hi = w - BLK;
    best = x;
    best_s = 0;
    for (int i = lo; i <= hi; i++) begin
      s = block_sad(y, x, i);
      if (i == lo || s < best_s) begin
        best_s = s;
        best = i;
      end
    end
    return (best > x) ? best - x : x - best;
  endfunction

  // store one pixel pair, queue the results it completes
  task automatic predict_pixel(input logic [7:0] l, input logic [7:0] r, output int n);
    int w, h, c, rw, y, lo, hi;
    out_item_t res[$];
    out_item_t o;
    w = eff_w();
    h = eff_h();
    c = pcol;
    rw = prow;
    n = 0;
    if (c >= w) begin
      c = 0;
      rw++;
    end
    if (rw >= h) rw = 0;
    left_st[(rw % BLK) * MAXW + c]  = l;
    right_st[(rw % BLK) * MAXW + c] = r;
    if (rw >= 2 * BLK - 1) begin
      y = rw - BLK + 1;
      if (y < h - BLK) begin
        if (c == w - 1) begin
          lo = w - SRCH - BLK;
          hi = w - BLK - 1;
        end else begin
          lo = c - SRCH - BLK + 1;
          hi = lo;
        end
        if (lo < BLK) lo = BLK;
        for (int x = lo; x <= hi && x < w - BLK; x++) begin
          o.map_column  = x[9:0];
          o.map_row     = y[9:0];
          o.disparity   = 5'(best_offset(y, x, w));
          o.last_of_run = 1'b0;
          res.push_back(o);
        end
      end
    end
    n = res.size();
    for (int i = 0; i < n; i++) begin
      o = res[i];
      if (i == n - 1) o.last_of_run = 1'b1;
      disp_q.push_back(o);
    end
    c++;
    if (c >= w) begin
      c = 0;
      rw++;
      if (rw >= h) rw = 0;
    end
    pcol = c & 32'h3FF;
    prow = rw & 32'h3FF;
  endtask

  // one input transfer, with an optional idle burst first
  task automatic send_pixel(input logic [7:0] l, input logic [7:0] r, output int n);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{left_pixel: l, right_pixel: r};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(l, r, n);
    n_pixels++;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) width_reg = data;
    else height_reg = data;
    n_cfg++;
  endtask

  // wait out every pending result, then the tail of a result-free pixel
  task automatic drain();
    in_valid <= 1'b0;
    while (disp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_frame(input int w, input int h, input pattern_e pat, input int shift_in,
                           input int pause_at);
    int c, shift, n, sent;
    logic [7:0] l, r, flat;
    drain();
    write_reg(REG_WIDTH, w[10:0]);
    write_reg(REG_HEIGHT, h[10:0]);
    flat = $urandom_range(0, 255);
    shift = shift_in;
    sent = 0;
    do begin
      c = (pcol >= eff_w()) ? 0 : pcol;
      // new texture row at the start of each line
      if (c == 0) begin
        for (int i = 0; i < MAXW + 2; i++) tex[i] = $urandom_range(0, 255);
        if (pat == PAT_MIXED) shift = $urandom_range(0, 3) - 1;
      end
      if (pat == PAT_FLAT) begin
        l = flat;
        r = flat;
      end else if (shift == 2) begin
        l = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end else begin
        l = tex[c + 1];
        r = tex[c + 1 - shift];
        if ($urandom_range(0, 15) == 0) r = $urandom_range(0, 255);
      end
      // hold the sender until the block has returned everything it owes
      if (sent == pause_at && disp_q.size() != 0) begin
        in_valid <= 1'b0;
        while (disp_q.size() != 0) @(posedge clk);
      end
      send_pixel(l, r, n);
      sent++;
    end while (!(pcol == 0 && prow == 0));
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (disp_q.size() == 0) begin
          report_mismatch("unexpected result, column", out_item.map_column, -1);
        end else begin
          if (out_item.map_column != disp_q[0].map_column)
            report_mismatch("map_column", out_item.map_column, disp_q[0].map_column);
          if (out_item.map_row != disp_q[0].map_row)
            report_mismatch("map_row", out_item.map_row, disp_q[0].map_row);
          if (out_item.disparity != disp_q[0].disparity)
            report_mismatch("disparity", out_item.disparity, disp_q[0].disparity);
          if (out_item.last_of_run != disp_q[0].last_of_run)
            report_mismatch("last_of_run", out_item.last_of_run, disp_q[0].last_of_run);
          void'(disp_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, disp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed rows: right after reset every pixel lands in row 0, so none gives a result
  dir_row_t dir_rows[] = '{
    '{8'h00, 8'h00, 1'b1}, '{8'hFF, 8'hFF, 1'b1}, '{8'h00, 8'hFF, 1'b1},
    '{8'hFF, 8'h00, 1'b1}, '{8'hAA, 8'h55, 1'b1}, '{8'h55, 8'hAA, 1'b1},
    '{8'h01, 8'h80, 1'b1}, '{8'h80, 8'h01, 1'b1}, '{8'h7F, 8'hFE, 1'b1},
    '{8'hFE, 8'h7F, 1'b1}, '{8'h0F, 8'hF0, 1'b1}, '{8'hF0, 8'h0F, 1'b1},
    '{8'h33, 8'hCC, 1'b1}, '{8'hCC, 8'h33, 1'b1}, '{8'h12, 8'h34, 1'b1},
    '{8'h9B, 8'h9B, 1'b1}
  };

  initial begin
    int n;
    for (int i = 0; i < BLK * MAXW; i++) begin
      left_st[i]  = '0;
      right_st[i] = '0;
    end
    pcol = 0;
    prow = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset sizes
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].l, dir_rows[i].r, n);
      if (dir_rows[i].no_result && n != 0) report_mismatch("results after reset row", n, 0);
    end

    // out-of-range sizes: zero width, oversized width and height
    drain();
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd2047);
    for (int i = 0; i < 6; i++) send_pixel($urandom_range(0, 255), $urandom_range(0, 255), n);
    drain();
    write_reg(REG_WIDTH, 11'd2047);
    write_reg(REG_HEIGHT, 11'd1024);
    for (int i = 0; i < 5; i++) send_pixel($urandom_range(0, 255), $urandom_range(0, 255), n);

    // 33x33 frame with mixed shifts, paused while results are owed
    run_frame(33, 33, PAT_MIXED, 0, 615);
    // ties on a flat frame
    run_frame(33, 33, PAT_FLAT, 0, -1);
    // closing frame without idles or stalls
    drain();
    idle_en = 1'b0;
    run_frame(40, 33, PAT_SHIFT, -1, -1);

    drain();
    $display("Covered %0d pixel transfers, %0d results, %0d register writes", n_pixels,
             n_results, n_cfg);
    $display("Sizes ran from out-of-range and full width down to the 33x33 minimum");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
